@@ sv/c3k_pkg.sv @@
// shared constants, types and helpers of the 3x3 kernel filter
package c3k_pkg;

	localparam int MAX_WIDTH = 32;
	localparam int COEF_BITS = 16;
	localparam int ROWS      = 3;
	localparam int DEPTH     = ROWS * MAX_WIDTH;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WID_W     = $clog2(MAX_WIDTH + 1);
	localparam int PIX_W     = 16;
	localparam int CH_W      = 8;
	localparam int CH_MAX    = 255;
	localparam int TAPS      = 9;
	localparam int ACC_W     = CH_W + COEF_BITS + 4;
	localparam int DIV_W     = 16;
	localparam int CFG_W     = 3 * COEF_BITS;

	typedef enum logic [2:0] {
		CFG_WIDTH,
		CFG_HEIGHT,
		CFG_KTOP,
		CFG_KMID,
		CFG_KBOT,
		CFG_DIV
	} cfg_idx_t;

	typedef logic [2:0][CH_W-1:0]  ch_vec_t;
	typedef logic [2:0][ACC_W-1:0] acc_vec_t;

	typedef struct packed {
		logic clear;
		logic en;
		logic row_start;
	} mac_ctl_t;

	// rgb565 to three 8-bit channels
	function automatic ch_vec_t unpack(input logic [PIX_W-1:0] p);
		ch_vec_t c;
		c[0] = {p[15:11], 3'b000};
		c[1] = {p[10:5], 2'b00};
		c[2] = {p[4:0], 3'b000};
		return c;
	endfunction

	// three 8-bit channels to rgb565
	function automatic logic [PIX_W-1:0] pack(input ch_vec_t c);
		return {c[0][7:3], c[1][7:2], c[2][7:3]};
	endfunction

endpackage

@@ sv/c3k_if.sv @@
// pixel stream interfaces of the 3x3 kernel filter
interface c3k_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_in;
	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface c3k_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_out;
	logic        run_end;
	logic        frame_end;
	modport source (output valid, output pixel_out, output run_end, output frame_end,
		input ready);
	modport sink (input valid, input pixel_out, input run_end, input frame_end,
		output ready);
endinterface

@@ sv/conv3x3_kernel_filter.sv @@
// top level of the 3x3 kernel filter: registers, counters and tap sequencer
//
// Pixels enter on pix_in in raster order and filtered pixels leave on pix_out
// with valid/ready handshakes; a transaction moves one pixel. Output runs one
// row behind: each input pixel causes zero, one or two results, and the last
// pixel of the frame also flushes the whole final row, run_end marking the
// last result of an input and frame_end the final pixel of the frame.
// Registers are written through cfg_we/cfg_index/cfg_data; the user writes
// them only while idle, which the block does not enforce. Each result walks
// the nine taps through one shared multiply-accumulate unit and then an
// eight-step restoring divider; a result whose centre pixel is transparent
// skips both and is zero. The line store's single read port and the divider
// steps set the pace. pix_in is ready only between items, so no pixel is
// taken before the last one's results are done. A stalled receiver holds the
// block once its next result is ready; the output register lets the block
// take the following pixel while the last result still waits. Reset clears
// counters and loads register defaults; the line store needs no clearing.
module conv3x3_kernel_filter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_index,
	input  logic [c3k_pkg::CFG_W-1:0] cfg_data,
	c3k_in_if.sink                    pix_in,
	c3k_out_if.source                 pix_out
);
	import c3k_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CTR,
		S_CHK,
		S_TAP,
		S_DIVS,
		S_DIVW,
		S_EMIT
	} state_t;

	// configuration registers
	logic [5:0]       frame_width_q;
	logic [15:0]      frame_height_q;
	logic [CFG_W-1:0] kernel_q [3];
	logic [DIV_W-1:0] divisor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 6'd32;
			frame_height_q <= 16'd32;
			kernel_q[0]    <= '0;
			kernel_q[1]    <= CFG_W'(1) << COEF_BITS;
			kernel_q[2]    <= '0;
			divisor_q      <= DIV_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:  frame_width_q  <= cfg_data[5:0];
				CFG_HEIGHT: frame_height_q <= cfg_data[15:0];
				CFG_KTOP:   kernel_q[0]    <= cfg_data;
				CFG_KMID:   kernel_q[1]    <= cfg_data;
				CFG_KBOT:   kernel_q[2]    <= cfg_data;
				CFG_DIV:    divisor_q      <= cfg_data[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry
	logic [WID_W-1:0] w_eff;
	logic [COL_W-1:0] wm1;
	logic [15:0]      h_eff;
	logic [15:0]      hm1;

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WID_W'(1);
		end else if (frame_width_q > 6'(MAX_WIDTH)) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = frame_width_q[WID_W-1:0];
		end
		wm1   = COL_W'(w_eff - 1'b1);
		h_eff = (frame_height_q == '0) ? 16'd1 : frame_height_q;
		hm1   = h_eff - 1'b1;
	end

	function automatic logic [1:0] m3_inc(input logic [1:0] m);
		return (m == 2'd2) ? 2'd0 : m + 2'd1;
	endfunction

	function automatic logic [1:0] m3_sub(input logic [1:0] m, input logic [1:0] b);
		return (m >= b) ? m - b : m + 2'd3 - b;
	endfunction

	// sequencer registers
	state_t           state_q;
	logic [COL_W-1:0] col_q;
	logic [15:0]      row_q;
	logic [1:0]       m3_q;
	logic [15:0]      job_row_q;
	logic [1:0]       job_m3_q;
	logic             job_back_q;
	logic             job_flush_q;
	logic             flush_pend_q;
	logic [COL_W-1:0] cur_x_q;
	logic [COL_W-1:0] end_x_q;
	logic [3:0]       tcnt_q;
	logic [1:0]       iy_q;
	logic [1:0]       ix_q;
	logic [1:0]       my_q;
	logic [1:0]       mx_q;
	logic             mac_en_q;
	logic [PIX_W-1:0] res_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             out_run_q;
	logic             out_frame_q;

	// counter wrap and job plan for the pixel being offered
	logic             accept;
	logic             col_ge;
	logic [COL_W-1:0] c_e;
	logic [16:0]      r_a;
	logic [1:0]       m_a;
	logic [15:0]      r_e;
	logic [1:0]       m_e;
	logic [16:0]      r_n;
	logic             has_a;
	logic             flush_now;

	always_comb begin
		accept = pix_in.valid && (state_q == S_IDLE);
		col_ge = WID_W'(col_q) >= w_eff;
		c_e    = col_ge ? '0 : col_q;
		r_a    = col_ge ? {1'b0, row_q} + 17'd1 : {1'b0, row_q};
		m_a    = col_ge ? m3_inc(m3_q) : m3_q;
		if (r_a >= {1'b0, h_eff}) begin
			r_e = '0;
			m_e = '0;
		end else begin
			r_e = r_a[15:0];
			m_e = m_a;
		end
		r_n       = {1'b0, r_e} + 17'd1;
		has_a     = (r_e != '0) && ((c_e != '0) || (c_e == wm1));
		flush_now = (r_e == hm1) && (c_e == wm1);
	end

	// store addressing: centre, then the nine taps
	logic [1:0]        tap_back;
	logic [1:0]        slot;
	logic [COL_W-1:0]  cx;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [PIX_W-1:0]  rdata;
	logic              y_pos;

	always_comb begin
		y_pos = job_row_q > {15'b0, job_back_q};
		if (state_q == S_CTR) begin
			tap_back = {1'b0, job_back_q};
			cx       = cur_x_q;
		end else begin
			case (iy_q)
				2'd0:    tap_back = {1'b0, job_back_q} + {1'b0, y_pos};
				2'd1:    tap_back = {1'b0, job_back_q};
				default: tap_back = 2'd0;
			endcase
			case (ix_q)
				2'd0:    cx = (cur_x_q != '0) ? cur_x_q - 1'b1 : cur_x_q;
				2'd1:    cx = cur_x_q;
				default: cx = (cur_x_q == wm1) ? cur_x_q : cur_x_q + 1'b1;
			endcase
		end
		slot  = m3_sub(job_m3_q, tap_back);
		raddr = ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cx));
		waddr = ADDR_W'(ADDR_W'(m_e) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_e));
	end

	c3k_store u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (waddr),
		.wdata (pix_in.pixel_in),
		.raddr (raddr),
		.rdata (rdata)
	);

	// coefficient of the tap in the accumulator
	logic [CFG_W-1:0]            krow;
	logic signed [COEF_BITS-1:0] coef;

	always_comb begin
		case (my_q)
			2'd0:    krow = kernel_q[0];
			2'd1:    krow = kernel_q[1];
			default: krow = kernel_q[2];
		endcase
		case (mx_q)
			2'd0:    coef = $signed(krow[0 +: COEF_BITS]);
			2'd1:    coef = $signed(krow[COEF_BITS +: COEF_BITS]);
			default: coef = $signed(krow[2*COEF_BITS +: COEF_BITS]);
		endcase
	end

	mac_ctl_t mac_ctl;
	acc_vec_t acc;

	assign mac_ctl.clear     = (state_q == S_CHK);
	assign mac_ctl.en        = mac_en_q;
	assign mac_ctl.row_start = (mx_q == 2'd0);

	c3k_mac u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.pix  (rdata),
		.coef (coef),
		.acc  (acc)
	);

	logic             div_done;
	logic [PIX_W-1:0] div_pix;

	c3k_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_DIVS),
		.acc     (acc),
		.divisor (divisor_q),
		.done    (div_done),
		.pixel   (div_pix)
	);

	// emit conditions for the current job
	logic out_free;
	logic job_last;
	logic run_last;

	always_comb begin
		out_free = !out_valid_q || pix_out.ready;
		job_last = (cur_x_q == end_x_q);
		run_last = job_last && (job_flush_q || !flush_pend_q);
	end

	// state machine, counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			col_q        <= '0;
			row_q        <= '0;
			m3_q         <= '0;
			mac_en_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			flush_pend_q <= 1'b0;
			job_flush_q  <= 1'b0;
			tcnt_q       <= '0;
			iy_q         <= '0;
			ix_q         <= '0;
		end else begin
			mac_en_q <= (state_q == S_TAP) && (tcnt_q != 4'(TAPS));
			my_q     <= iy_q;
			mx_q     <= ix_q;
			if (out_valid_q && pix_out.ready && !((state_q == S_EMIT) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (c_e == wm1) begin
							col_q <= '0;
							if (r_n >= {1'b0, h_eff}) begin
								row_q <= '0;
								m3_q  <= '0;
							end else begin
								row_q <= r_n[15:0];
								m3_q  <= m3_inc(m_e);
							end
						end else begin
							col_q <= c_e + 1'b1;
							row_q <= r_e;
							m3_q  <= m_e;
						end
						job_row_q    <= r_e;
						job_m3_q     <= m_e;
						flush_pend_q <= flush_now;
						if (has_a) begin
							job_back_q  <= 1'b1;
							job_flush_q <= 1'b0;
							cur_x_q     <= (c_e != '0) ? c_e - 1'b1 : c_e;
							end_x_q     <= (c_e == wm1) ? c_e : c_e - 1'b1;
							state_q     <= S_CTR;
						end else if (flush_now) begin
							job_back_q  <= 1'b0;
							job_flush_q <= 1'b1;
							cur_x_q     <= '0;
							end_x_q     <= wm1;
							state_q     <= S_CTR;
						end
					end
				end
				S_CTR: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (rdata == '0) begin
						res_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						tcnt_q  <= '0;
						iy_q    <= '0;
						ix_q    <= '0;
						state_q <= S_TAP;
					end
				end
				S_TAP: begin
					if (tcnt_q == 4'(TAPS)) begin
						state_q <= S_DIVS;
					end else begin
						tcnt_q <= tcnt_q + 1'b1;
						if (ix_q == 2'd2) begin
							ix_q <= '0;
							iy_q <= iy_q + 1'b1;
						end else begin
							ix_q <= ix_q + 1'b1;
						end
					end
				end
				S_DIVS: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						res_q   <= div_pix;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_pix_q   <= res_q;
						out_run_q   <= run_last;
						out_frame_q <= job_flush_q && (cur_x_q == wm1);
						if (!job_last) begin
							cur_x_q <= cur_x_q + 1'b1;
							state_q <= S_CTR;
						end else if (!job_flush_q && flush_pend_q) begin
							job_back_q  <= 1'b0;
							job_flush_q <= 1'b1;
							cur_x_q     <= '0;
							end_x_q     <= wm1;
							state_q     <= S_CTR;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign pix_in.ready      = (state_q == S_IDLE);
	assign pix_out.valid     = out_valid_q;
	assign pix_out.pixel_out = out_pix_q;
	assign pix_out.run_end   = out_run_q;
	assign pix_out.frame_end = out_frame_q;

endmodule

@@ sv/c3k_store.sv @@
// three-row line store, one write and one registered read port
module c3k_store (
	input  logic                      clk,
	input  logic                      we,
	input  logic [c3k_pkg::ADDR_W-1:0] waddr,
	input  logic [c3k_pkg::PIX_W-1:0]  wdata,
	input  logic [c3k_pkg::ADDR_W-1:0] raddr,
	output logic [c3k_pkg::PIX_W-1:0]  rdata
);
	import c3k_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ sv/c3k_mac.sv @@
// shared multiply-accumulate unit, one tap per cycle across three channels
module c3k_mac (
	input  logic                                clk,
	input  c3k_pkg::mac_ctl_t                   ctl,
	input  logic [c3k_pkg::PIX_W-1:0]           pix,
	input  logic signed [c3k_pkg::COEF_BITS-1:0] coef,
	output c3k_pkg::acc_vec_t                   acc
);
	import c3k_pkg::*;

	ch_vec_t prev_q;
	ch_vec_t cur;
	ch_vec_t base;
	acc_vec_t acc_q;
	logic signed [CH_W+COEF_BITS:0] prod [3];

	// transparent tap reuses the previous colour of its kernel row
	always_comb begin
		base = ctl.row_start ? '0 : prev_q;
		cur  = (pix != '0) ? unpack(pix) : base;
		for (int ch = 0; ch < 3; ch++) begin
			prod[ch] = $signed({1'b0, cur[ch]}) * coef;
		end
	end

	// accumulate
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			prev_q <= cur;
			for (int ch = 0; ch < 3; ch++) begin
				acc_q[ch] <= ACC_W'($signed(acc_q[ch]) + ACC_W'(prod[ch]));
			end
		end
	end

	assign acc = acc_q;

endmodule

@@ sv/c3k_div.sv @@
// signed divide, clamp and pack: restoring divider over three lanes
module c3k_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  c3k_pkg::acc_vec_t           acc,
	input  logic [c3k_pkg::DIV_W-1:0]   divisor,
	output logic                        done,
	output logic [c3k_pkg::PIX_W-1:0]   pixel
);
	import c3k_pkg::*;

	localparam int CNT_W = $clog2(CH_W + 1);

	logic signed [DIV_W-1:0] d_nz;
	logic [DIV_W-1:0]        dmag;
	logic                    neg_d;
	logic [ACC_W-1:0]        rem_q [3];
	logic [CH_W-1:0]         quo_q [3];
	logic [2:0]              pos_q;
	logic [2:0]              ovf_q;
	logic [ACC_W-1:0]        dsh_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;
	ch_vec_t                 ch;

	// zero divisor counts as one
	always_comb begin
		d_nz  = ($signed(divisor) == 0) ? DIV_W'(1) : $signed(divisor);
		neg_d = d_nz[DIV_W-1];
		dmag  = neg_d ? DIV_W'(-d_nz) : DIV_W'(d_nz);
	end

	// sequencer and lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				for (int i = 0; i < 3; i++) begin
					logic signed [ACC_W-1:0] a;
					logic [ACC_W-1:0]        mag;
					a        = $signed(acc[i]);
					mag      = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
					rem_q[i] <= mag;
					quo_q[i] <= '0;
					pos_q[i] <= (a != 0) && (a[ACC_W-1] == neg_d);
					ovf_q[i] <= mag >= (ACC_W'(dmag) << CH_W);
				end
				dsh_q  <= ACC_W'(dmag) << (CH_W - 1);
				cnt_q  <= CNT_W'(CH_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_q[i] >= dsh_q) begin
						rem_q[i] <= rem_q[i] - dsh_q;
						quo_q[i] <= {quo_q[i][CH_W-2:0], 1'b1};
					end else begin
						quo_q[i] <= {quo_q[i][CH_W-2:0], 1'b0};
					end
				end
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// clamp to 0..255 and repack
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!pos_q[i]) begin
				ch[i] = '0;
			end else if (ovf_q[i]) begin
				ch[i] = CH_W'(CH_MAX);
			end else begin
				ch[i] = quo_q[i];
			end
		end
		pixel = pack(ch);
	end

	assign done = done_q;

endmodule

@@ sv/c3k_checker.sv @@
// port-level checks of the 3x3 kernel filter, bound to the top level
module c3k_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] pixel_out,
	input logic        run_end,
	input logic        frame_end
);

	// a stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(run_end)
			&& $stable(frame_end))
		else $error("stalled output changed");

	// a new result appears only while the input side is closed
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result produced while accepting input");

	// the frame's final pixel always closes its run
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_end)
		else $error("frame_end without run_end");

	// after a stall with the input closed, the input reopens only with a result still held
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !in_ready |=> !in_ready || out_valid)
		else $error("input reopened with result lost");

endmodule

bind conv3x3_kernel_filter c3k_checker u_c3k_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.pixel_out (pix_out.pixel_out),
	.run_end   (pix_out.run_end),
	.frame_end (pix_out.frame_end)
);

@@ bench/tb_conv3x3_kernel_filter.sv @@
// self-checking testbench of the 3x3 kernel filter with its own prediction of the filtered stream
module tb_conv3x3_kernel_filter;
	timeunit 1ns;
	timeprecision 1ps;
	import c3k_pkg::*;

	typedef struct {
		logic [15:0] pixel;
		logic        run_end;
		logic        frame_end;
	} filt_result_t;

	// predicted filter state and the queue of filtered pixels still owed
	class filter_scoreboard;
		logic [15:0]  line_mem [DEPTH];
		int unsigned  col, row;
		logic [5:0]   width_reg;
		logic [15:0]  height_reg;
		logic [47:0]  kern [3];
		logic [15:0]  div_reg;
		filt_result_t owed [$];
		int           errors;
		int           checked;

		function void reset_state();
			foreach (line_mem[i]) line_mem[i] = '0;
			col = 0;
			row = 0;
			width_reg = 6'd32;
			height_reg = 16'd32;
			kern[0] = '0;
			kern[1] = 48'd65536;
			kern[2] = '0;
			div_reg = 16'd1;
			owed.delete();
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [47:0] val);
			case (idx)
				CFG_WIDTH:  width_reg = val[5:0];
				CFG_HEIGHT: height_reg = val[15:0];
				CFG_KTOP:   kern[0] = val;
				CFG_KMID:   kern[1] = val;
				CFG_KBOT:   kern[2] = val;
				CFG_DIV:    div_reg = val[15:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_w();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_WIDTH) return MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned eff_h();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function logic [15:0] mem_at(int unsigned r, int unsigned c);
			return line_mem[(r % 3) * MAX_WIDTH + c];
		endfunction

		// nine taps, transparent taps repeat the previous colour of their row
		function logic [15:0] filtered_pixel(int unsigned x, int unsigned y,
				int unsigned w, int unsigned h);
			longint acc [3];
			longint prev [3];
			longint c, d;
			int unsigned ry, cx;
			logic [15:0] p;
			logic [7:0] ch [3];
			if (mem_at(y, x) == 0) return 16'd0;
			acc = '{0, 0, 0};
			for (int ky = 0; ky < 3; ky++) begin
				prev = '{0, 0, 0};
				ry = y + ky;
				ry = (ry == 0) ? 0 : ry - 1;
				if (ry > h - 1) ry = h - 1;
				for (int kx = 0; kx < 3; kx++) begin
					c = longint'($signed(kern[ky][kx*16 +: 16]));
					cx = x + kx;
					cx = (cx == 0) ? 0 : cx - 1;
					if (cx > w - 1) cx = w - 1;
					p = mem_at(ry, cx);
					if (p != 0) begin
						prev[0] = {p[15:11], 3'b000};
						prev[1] = {p[10:5], 2'b00};
						prev[2] = {p[4:0], 3'b000};
					end
					for (int k = 0; k < 3; k++) acc[k] += prev[k] * c;
				end
			end
			d = longint'($signed(div_reg));
			if (d == 0) d = 1;
			for (int k = 0; k < 3; k++) begin
				acc[k] = acc[k] / d;
				if (acc[k] > 255) acc[k] = 255;
				if (acc[k] < 0) acc[k] = 0;
				ch[k] = acc[k][7:0];
			end
			if (ch[0] == 0 && ch[1] == 0 && ch[2] == 0) return 16'd0;
			return {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
		endfunction

		// accepted input pixel: store it and queue what it causes
		function void note_pixel(logic [15:0] pix);
			int unsigned w, h;
			filt_result_t r;
			int first;
			w = eff_w();
			h = eff_h();
			first = owed.size();
			if (col >= w) begin
				col = 0;
				row++;
			end
			if (row >= h) row = 0;
			line_mem[(row % 3) * MAX_WIDTH + col] = pix;
			r.run_end = 1'b0;
			r.frame_end = 1'b0;
			if (row >= 1) begin
				if (col >= 1) begin
					r.pixel = filtered_pixel(col - 1, row - 1, w, h);
					owed.push_back(r);
				end
				if (col == w - 1) begin
					r.pixel = filtered_pixel(col, row - 1, w, h);
					owed.push_back(r);
				end
			end
			if (row == h - 1 && col == w - 1) begin
				for (int unsigned x = 0; x < w; x++) begin
					r.pixel = filtered_pixel(x, row, w, h);
					r.frame_end = (x == w - 1);
					owed.push_back(r);
				end
			end
			if (owed.size() > first) owed[owed.size() - 1].run_end = 1'b1;
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) row = 0;
			end
		endfunction

		function void check_result(logic [15:0] pix, logic re, logic fe);
			filt_result_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result pixel %h run_end %b frame_end %b",
					$time, pix, re, fe);
				errors++;
				return;
			end
			e = owed.pop_front();
			checked++;
			if (pix !== e.pixel) begin
				$display("%0t: pixel_out expected %h actual %h", $time, e.pixel, pix);
				errors++;
			end
			if (re !== e.run_end) begin
				$display("%0t: run_end expected %b actual %b", $time, e.run_end, re);
				errors++;
			end
			if (fe !== e.frame_end) begin
				$display("%0t: frame_end expected %b actual %b", $time, e.frame_end, fe);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	bit          idle_on;
	int          pixels_sent;
	int          phases_run;
	filter_scoreboard sb;

	c3k_in_if  pix_in_if ();
	c3k_out_if pix_out_if ();

	conv3x3_kernel_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix_in_if.sink),
		.pix_out   (pix_out_if.source)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	// receiver with random back-pressure
	always @(posedge clk) begin
		if (arst_n && pix_out_if.valid && pix_out_if.ready)
			sb.check_result(pix_out_if.pixel_out, pix_out_if.run_end, pix_out_if.frame_end);
		pix_out_if.ready <= !idle_on || ($urandom_range(99) >= 28);
	end

	task automatic write_reg(cfg_idx_t idx, logic [47:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic send_pixel(logic [15:0] pix);
		if (idle_on && $urandom_range(99) < 28) begin
			pix_in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		pix_in_if.valid <= 1'b1;
		pix_in_if.pixel_in <= pix;
		do @(posedge clk); while (!pix_in_if.ready);
		sb.note_pixel(pix);
		pixels_sent++;
	endtask

	task automatic drain(int settle);
		pix_in_if.valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic load_setup(logic [5:0] w, logic [15:0] h, logic [47:0] kt,
			logic [47:0] km, logic [47:0] kb, logic [47:0] dv);
		drain(80);
		write_reg(CFG_WIDTH, {42'd0, w});
		write_reg(CFG_HEIGHT, {32'd0, h});
		write_reg(CFG_KTOP, kt);
		write_reg(CFG_KMID, km);
		write_reg(CFG_KBOT, kb);
		write_reg(CFG_DIV, dv);
		phases_run++;
	endtask

	function automatic logic [15:0] rand_pixel();
		int sel;
		sel = $urandom_range(99);
		if (sel < 20) return 16'h0000;
		if (sel < 28) return 16'hffff;
		return 16'($urandom);
	endfunction

	function automatic logic [47:0] rand_kernel();
		logic [47:0] k;
		if ($urandom_range(4) == 0) return {16'($urandom), 32'($urandom)};
		for (int i = 0; i < 3; i++) k[i*16 +: 16] = 16'($signed($urandom_range(8)) - 4);
		return k;
	endfunction

	function automatic logic [47:0] rand_divisor();
		logic [15:0] d;
		case ($urandom_range(7))
			0: d = 16'd0;
			1: d = 16'h8000;
			2: d = 16'h7fff;
			3: d = -16'($urandom_range(1, 9));
			4: d = 16'($urandom);
			default: d = 16'($urandom_range(1, 9));
		endcase
		return {16'($urandom), 16'($urandom), d};
	endfunction

	initial begin
		logic [5:0]  w;
		logic [15:0] h;
		int unsigned n_items;
		int          frames;
		sb = new();
		sb.reset_state();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		pixels_sent = 0;
		phases_run = 0;
		pix_in_if.valid = 1'b0;
		pix_in_if.pixel_in = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// single-pixel frames: extremes and transparent centre
		load_setup(6'd1, 16'd1, 48'd0, 48'd65536, 48'd0, 48'd1);
		send_pixel(16'h0000);
		send_pixel(16'hffff);
		send_pixel(16'h0001);
		send_pixel(16'h8000);
		send_pixel(16'h07e0);
		send_pixel(16'h0821);

		// 3x3 frame, extreme coefficients and zero divisor
		load_setup(6'd3, 16'd3, 48'h8000_7fff_8000, 48'h7fff_0001_ffff,
			48'h0000_8000_7fff, {32'hffff_ffff, 16'd0});
		send_pixel(16'hffff); send_pixel(16'h0000); send_pixel(16'h1234);
		send_pixel(16'h0000); send_pixel(16'hffff); send_pixel(16'h0000);
		send_pixel(16'h8410); send_pixel(16'h0000); send_pixel(16'hf81f);

		// 3x3 frame, transparent neighbours with a negative divisor
		load_setup(6'd3, 16'd3, 48'h0001_0001_0001, 48'h0001_0002_0001,
			48'h0001_0001_0001, 48'hffff);
		send_pixel(16'h0000); send_pixel(16'h4208); send_pixel(16'h0000);
		send_pixel(16'hffff); send_pixel(16'h0000); send_pixel(16'h0000);
		send_pixel(16'h0000); send_pixel(16'h2104); send_pixel(16'hffff);

		// random phases, the first free of idling
		idle_on = 1'b0;
		while (pixels_sent < 215) begin
			case ($urandom_range(9))
				0: begin w = 6'd32; h = 16'($urandom_range(1, 2)); end
				1: begin w = 6'd0; h = 16'($urandom_range(1, 4)); end
				2: begin w = 6'd63; h = 16'd1; end
				3: begin w = 6'($urandom_range(1, 8)); h = 16'd0; end
				default: begin w = 6'($urandom_range(1, 8)); h = 16'($urandom_range(1, 4)); end
			endcase
			load_setup(w, h, rand_kernel(), rand_kernel(), rand_kernel(), rand_divisor());
			frames = (sb.eff_w() > 8) ? 1 : $urandom_range(1, 3);
			n_items = sb.eff_w() * sb.eff_h() * frames;
			for (int unsigned i = 0; i < n_items; i++) begin
				// in the fifth register setup, the sender holds off halfway until the block has caught up
				if (phases_run == 5 && i == n_items / 2) drain(0);
				send_pixel(rand_pixel());
			end
			if (pixels_sent >= 90) idle_on = 1'b1;
		end

		drain(120);
		$display("run covered %0d pixels over %0d register setups, %0d results checked",
			pixels_sent, phases_run, sb.checked);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/c3k_pkg.sv
sv/c3k_if.sv
sv/c3k_store.sv
sv/c3k_mac.sv
sv/c3k_div.sv
sv/conv3x3_kernel_filter.sv
sv/c3k_checker.sv
bench/tb_conv3x3_kernel_filter.sv
